// ----- rtl/bnc_pkg.sv -----
// Shared types, constants and decode functions for the bracket nesting checker.
package bnc_pkg;

   localparam int unsigned STACK_DEPTH_DEF = 64;
   localparam int unsigned CHAR_W          = 8;
   localparam int unsigned STATUS_W        = 2;
   localparam int unsigned SYNTAX_W        = 15;
   localparam int unsigned SCORE_W         = 63;
   localparam int unsigned KIND_W          = 2;

   localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

   // ASCII codes of the four bracket pairs
   localparam logic [CHAR_W-1:0] CH_ROUND_OPEN   = 8'h28;
   localparam logic [CHAR_W-1:0] CH_ROUND_CLOSE  = 8'h29;
   localparam logic [CHAR_W-1:0] CH_SQUARE_OPEN  = 8'h5B;
   localparam logic [CHAR_W-1:0] CH_SQUARE_CLOSE = 8'h5D;
   localparam logic [CHAR_W-1:0] CH_CURLY_OPEN   = 8'h7B;
   localparam logic [CHAR_W-1:0] CH_CURLY_CLOSE  = 8'h7D;
   localparam logic [CHAR_W-1:0] CH_ANGLE_OPEN   = 8'h3C;
   localparam logic [CHAR_W-1:0] CH_ANGLE_CLOSE  = 8'h3E;

   typedef logic [KIND_W-1:0] kind_type;

   localparam kind_type KIND_ROUND  = 2'd0;
   localparam kind_type KIND_SQUARE = 2'd1;
   localparam kind_type KIND_CURLY  = 2'd2;
   localparam kind_type KIND_ANGLE  = 2'd3;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_BALANCED   = 2'd0,
      STATUS_CORRUPT    = 2'd1,
      STATUS_INCOMPLETE = 2'd2,
      STATUS_OVERFLOW   = 2'd3
   } status_type;

   typedef struct packed {
      logic     hit;
      kind_type kind;
   } decode_type;

   // Opening bracket decode
   function automatic decode_type opener_decode(input logic [CHAR_W-1:0] c);
      decode_type d;
      d.hit  = 1'b1;
      d.kind = KIND_ROUND;
      case (c)
         CH_ROUND_OPEN:  d.kind = KIND_ROUND;
         CH_SQUARE_OPEN: d.kind = KIND_SQUARE;
         CH_CURLY_OPEN:  d.kind = KIND_CURLY;
         CH_ANGLE_OPEN:  d.kind = KIND_ANGLE;
         default:        d.hit  = 1'b0;
      endcase
      return d;
   endfunction

   // Closing bracket decode
   function automatic decode_type closer_decode(input logic [CHAR_W-1:0] c);
      decode_type d;
      d.hit  = 1'b1;
      d.kind = KIND_ROUND;
      case (c)
         CH_ROUND_CLOSE:  d.kind = KIND_ROUND;
         CH_SQUARE_CLOSE: d.kind = KIND_SQUARE;
         CH_CURLY_CLOSE:  d.kind = KIND_CURLY;
         CH_ANGLE_CLOSE:  d.kind = KIND_ANGLE;
         default:         d.hit  = 1'b0;
      endcase
      return d;
   endfunction

   // Points for an illegal closer, zero for anything else
   function automatic logic [SYNTAX_W-1:0] syntax_points(input logic [CHAR_W-1:0] c);
      decode_type d;
      logic [SYNTAX_W-1:0] p;
      d = closer_decode(c);
      unique case (d.kind)
         KIND_ROUND:  p = 15'd3;
         KIND_SQUARE: p = 15'd57;
         KIND_CURLY:  p = 15'd1197;
         KIND_ANGLE:  p = 15'd25137;
      endcase
      return d.hit ? p : '0;
   endfunction

endpackage

// ----- rtl/bnc_if.sv -----
// Valid/ready channel interfaces for line characters and line results.
interface bnc_req_if;
   logic                         valid;
   logic                         ready;
   logic [bnc_pkg::CHAR_W-1:0]   character;
   logic                         last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface

interface bnc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bnc_pkg::STATUS_W-1:0]  status;
   logic [bnc_pkg::CHAR_W-1:0]    bad_char;
   logic [bnc_pkg::SYNTAX_W-1:0]  syntax_score;
   logic [bnc_pkg::SCORE_W-1:0]   completion_score;

   modport source (output valid, output status, output bad_char, output syntax_score,
                   output completion_score, input ready);
   modport sink   (input valid, input status, input bad_char, input syntax_score,
                   input completion_score, output ready);
endinterface

// ----- rtl/bnc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bnc_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/bracket_nesting_checker.sv -----
// Bracket nesting checker: a stack of open bracket kinds kept in RAM.
// A closer that leaves the stack non-empty adds a load state, in which the input is
// stalled while the RAM read refreshes the cached top entry.
// On the last character the result passes through the finish state into the result
// register; when incomplete, a walk state first reads the open entries (one RAM read a cycle).
// Synchronous reset clears line state, the result valid flag and the sequencer.
module bracket_nesting_checker #(
   parameter int unsigned STACK_DEPTH = bnc_pkg::STACK_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   bnc_req_if.sink           req_bus,
   bnc_rsp_if.source         rsp_bus
);
   import bnc_pkg::*;

   localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int unsigned LW = $clog2(STACK_DEPTH + 1);
   localparam logic [LW-1:0] DEPTH_L = LW'(STACK_DEPTH);

   typedef enum logic [1:0] {
      ST_ACCEPT,
      ST_LOAD,
      ST_WALK,
      ST_FINISH
   } state_type;

   // Sequencer and line state
   state_type          state_ff, state_in;
   logic [LW-1:0]      level_ff, level_in;
   kind_type           tos_ff, tos_in;
   logic               corrupt_ff, corrupt_in;
   logic               overflow_ff, overflow_in;
   logic [CHAR_W-1:0]  bad_ff, bad_in;

   // Pending result and end-of-line walk
   status_type         res_status_ff, res_status_in;
   logic [CHAR_W-1:0]  res_bad_ff, res_bad_in;
   logic [SCORE_W-1:0] score_ff, score_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic [LW-1:0]      cnt_ff, cnt_in;
   logic               rvalid_ff, rvalid_in;

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          out_status_ff, out_status_in;
   logic [CHAR_W-1:0]   out_bad_ff, out_bad_in;
   logic [SYNTAX_W-1:0] out_syntax_ff, out_syntax_in;
   logic [SCORE_W-1:0]  out_score_ff, out_score_in;

   // RAM port signals
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   kind_type      ram_wdata;
   logic [AW-1:0] ram_raddr;
   kind_type      ram_rdata;

   logic       accept;
   decode_type op;
   decode_type cl;
   logic [LW-1:0] n_level;
   logic          n_corrupt;
   logic          n_overflow;
   logic [CHAR_W-1:0] n_bad;
   logic          n_load;
   logic [SCORE_W+2:0] fold_sum;

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == ST_ACCEPT);
   assign op            = opener_decode(req_bus.character);
   assign cl            = closer_decode(req_bus.character);

   // score*5 + digit, with room to see overflow past 63 bits
   assign fold_sum = {1'b0, score_ff, 2'b00} + {3'b000, score_ff}
                   + (SCORE_W+3)'(ram_rdata) + (SCORE_W+3)'(1);

   bnc_ram #(
      .WIDTH (KIND_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Character step: push, matched pop, corrupt or overflow
   always_comb begin
      n_level    = level_ff;
      n_corrupt  = corrupt_ff;
      n_overflow = overflow_ff;
      n_bad      = bad_ff;
      n_load     = 1'b0;
      tos_in     = tos_ff;
      ram_we     = 1'b0;
      ram_waddr  = level_ff[AW-1:0];
      ram_wdata  = op.kind;
      if (accept && !corrupt_ff && !overflow_ff) begin
         if (op.hit) begin
            if (level_ff < DEPTH_L) begin
               ram_we  = 1'b1;
               n_level = level_ff + LW'(1);
               tos_in  = op.kind;
            end else begin
               n_overflow = 1'b1;
            end
         end else if (cl.hit) begin
            if (level_ff == '0 || tos_ff != cl.kind) begin
               n_corrupt = 1'b1;
               n_bad     = req_bus.character;
            end else begin
               n_level = level_ff - LW'(1);
               n_load  = (n_level != '0);
            end
         end
      end
      if (state_ff == ST_LOAD) begin
         tos_in = ram_rdata;
      end
   end

   // Read address: new top after a pop, or the walk index
   assign ram_raddr = (state_ff == ST_WALK) ? idx_ff : AW'(level_ff - LW'(2));

   // Sequencer next state
   always_comb begin
      state_in      = state_ff;
      level_in      = level_ff;
      corrupt_in    = corrupt_ff;
      overflow_in   = overflow_ff;
      bad_in        = bad_ff;
      res_status_in = res_status_ff;
      res_bad_in    = res_bad_ff;
      score_in      = score_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      rvalid_in     = 1'b0;
      rsp_valid_in  = rsp_valid_ff;
      out_status_in = out_status_ff;
      out_bad_in    = out_bad_ff;
      out_syntax_in = out_syntax_ff;
      out_score_in  = out_score_ff;

      // result beat taken downstream
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_ACCEPT: begin
            if (accept) begin
               if (req_bus.last) begin
                  level_in    = '0;
                  corrupt_in  = 1'b0;
                  overflow_in = 1'b0;
                  bad_in      = '0;
                  res_bad_in  = n_corrupt ? n_bad : '0;
                  score_in    = '0;
                  idx_in      = AW'(n_level - LW'(1));
                  cnt_in      = n_level;
                  state_in    = ST_FINISH;
                  priority if (n_corrupt) begin
                     res_status_in = STATUS_CORRUPT;
                  end else if (n_overflow) begin
                     res_status_in = STATUS_OVERFLOW;
                  end else if (n_level == '0) begin
                     res_status_in = STATUS_BALANCED;
                  end else begin
                     res_status_in = STATUS_INCOMPLETE;
                     state_in      = ST_WALK;
                  end
               end else begin
                  level_in    = n_level;
                  corrupt_in  = n_corrupt;
                  overflow_in = n_overflow;
                  bad_in      = n_bad;
                  state_in    = n_load ? ST_LOAD : ST_ACCEPT;
               end
            end
         end
         ST_LOAD: begin
            state_in = ST_ACCEPT;
         end
         ST_WALK: begin
            // one read issued per cycle, top entry first; fold each entry once its registered read data returns
            if (cnt_ff != '0) begin
               idx_in    = idx_ff - AW'(1);
               cnt_in    = cnt_ff - LW'(1);
               rvalid_in = 1'b1;
            end
            if (rvalid_ff) begin
               score_in = (fold_sum[SCORE_W+2:SCORE_W] != '0) ? SCORE_MAX
                                                               : fold_sum[SCORE_W-1:0];
            end
            if (cnt_ff == '0 && !rvalid_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               out_status_in = res_status_ff;
               out_bad_in    = res_bad_ff;
               out_syntax_in = (res_status_ff == STATUS_CORRUPT) ? syntax_points(res_bad_ff)
                                                                 : '0;
               out_score_in  = score_ff;
               state_in      = ST_ACCEPT;
            end
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCEPT;
         level_ff     <= '0;
         corrupt_ff   <= 1'b0;
         overflow_ff  <= 1'b0;
         bad_ff       <= '0;
         cnt_ff       <= '0;
         rvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         corrupt_ff   <= corrupt_in;
         overflow_ff  <= overflow_in;
         bad_ff       <= bad_in;
         cnt_ff       <= cnt_in;
         rvalid_ff    <= rvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tos_ff        <= tos_in;
      res_status_ff <= res_status_in;
      res_bad_ff    <= res_bad_in;
      score_ff      <= score_in;
      idx_ff        <= idx_in;
      out_status_ff <= out_status_in;
      out_bad_ff    <= out_bad_in;
      out_syntax_ff <= out_syntax_in;
      out_score_ff  <= out_score_in;
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.status           = out_status_ff;
   assign rsp_bus.bad_char         = out_bad_ff;
   assign rsp_bus.syntax_score     = out_syntax_ff;
   assign rsp_bus.completion_score = out_score_ff;

endmodule

// ----- rtl/bnc_checker.sv -----
// Port-level assertions for the bracket nesting checker, bound into the checker module.
module bnc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [bnc_pkg::STATUS_W-1:0]  rsp_status,
   input logic [bnc_pkg::CHAR_W-1:0]    rsp_bad_char,
   input logic [bnc_pkg::SYNTAX_W-1:0]  rsp_syntax_score,
   input logic [bnc_pkg::SCORE_W-1:0]   rsp_completion_score
);
   import bnc_pkg::*;

   // a result beat waits until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped before it was taken");

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat shown after reset");

   // corrupt line carries a closer's points, other lines none
   a_syntax: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_status == STATUS_CORRUPT) ?
         (rsp_syntax_score == 15'd3 || rsp_syntax_score == 15'd57 ||
          rsp_syntax_score == 15'd1197 || rsp_syntax_score == 15'd25137) :
         (rsp_syntax_score == '0 && rsp_bad_char == '0)))
      else $error("syntax score or bad character inconsistent with status");

   // completion score only on an incomplete line, never zero there
   a_completion: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_status == STATUS_INCOMPLETE) ? (rsp_completion_score != '0)
                                                       : (rsp_completion_score == '0)))
      else $error("completion score inconsistent with status");

endmodule

bind bracket_nesting_checker bnc_checker u_bnc_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_bus.valid),
   .rsp_ready            (rsp_bus.ready),
   .rsp_status           (rsp_bus.status),
   .rsp_bad_char         (rsp_bus.bad_char),
   .rsp_syntax_score     (rsp_bus.syntax_score),
   .rsp_completion_score (rsp_bus.completion_score)
);

// ----- bench/bracket_nesting_checker_tb.sv -----
// Self-checking bench for the bracket nesting checker: line predictor, random lines, back-pressure.
module bracket_nesting_checker_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bnc_pkg::*;

   localparam int unsigned HOLD_CYCLES   = 200;
   localparam int unsigned SETTLE_CYCLES = STACK_DEPTH_DEF + 16;
   localparam int unsigned PHASE_BEATS   = 80;
   localparam int unsigned REPORT_LIMIT  = 10;

   typedef struct packed {
      status_type          status;
      logic [CHAR_W-1:0]   bad_char;
      logic [SYNTAX_W-1:0] syntax_score;
      logic [SCORE_W-1:0]  completion_score;
   } line_result_type;

   typedef enum int {
      LINE_BALANCED,
      LINE_INCOMPLETE,
      LINE_CORRUPT,
      LINE_NOISE,
      LINE_DEEP,
      LINE_OVERFLOW
   } line_shape_type;

   // Tracks the nesting of the current line and queues the verdict of each finished line
   class bracket_line_board;
      kind_type        open_kinds[$];
      bit              line_corrupt;
      bit              line_overflow;
      logic [7:0]      bad_closer;
      line_result_type awaited_results[$];
      int unsigned     mismatches;

      function kind_type kind_of(logic [7:0] c);
         case (c)
            CH_SQUARE_OPEN, CH_SQUARE_CLOSE: return KIND_SQUARE;
            CH_CURLY_OPEN, CH_CURLY_CLOSE:   return KIND_CURLY;
            CH_ANGLE_OPEN, CH_ANGLE_CLOSE:   return KIND_ANGLE;
            default:                         return KIND_ROUND;
         endcase
      endfunction

      function int unsigned pending();
         return awaited_results.size();
      endfunction

      // One accepted character beat
      function void note_char(logic [7:0] c, logic fin);
         line_result_type r;
         logic [63:0]     score;
         logic [63:0]     v;
         logic [63:0]     cap;
         cap = {1'b0, SCORE_MAX};
         // once corrupt or overflowed, the rest of the line is ignored
         if (!line_corrupt && !line_overflow) begin
            case (c)
               CH_ROUND_OPEN, CH_SQUARE_OPEN, CH_CURLY_OPEN, CH_ANGLE_OPEN: begin
                  if (open_kinds.size() < STACK_DEPTH_DEF)
                     open_kinds.insert(open_kinds.size(), kind_of(c));
                  else line_overflow = 1'b1;
               end
               CH_ROUND_CLOSE, CH_SQUARE_CLOSE, CH_CURLY_CLOSE, CH_ANGLE_CLOSE: begin
                  if (open_kinds.size() == 0 || open_kinds[$] != kind_of(c)) begin
                     line_corrupt = 1'b1;
                     bad_closer   = c;
                  end else begin
                     open_kinds.delete(open_kinds.size() - 1);
                  end
               end
               default: ;
            endcase
         end
         if (!fin) return;

         r = '0;
         if (line_corrupt) begin
            r.status   = STATUS_CORRUPT;
            r.bad_char = bad_closer;
            case (kind_of(bad_closer))
               KIND_ROUND:  r.syntax_score = 15'd3;
               KIND_SQUARE: r.syntax_score = 15'd57;
               KIND_CURLY:  r.syntax_score = 15'd1197;
               default:     r.syntax_score = 15'd25137;
            endcase
         end else if (line_overflow) begin
            r.status = STATUS_OVERFLOW;
         end else if (open_kinds.size() == 0) begin
            r.status = STATUS_BALANCED;
         end else begin
            // base-5 fold from the top of the stack down, saturating
            r.status = STATUS_INCOMPLETE;
            score = '0;
            for (int i = open_kinds.size() - 1; i >= 0; i--) begin
               v = 64'(open_kinds[i]) + 64'd1;
               if (score > (cap - v) / 64'd5) begin
                  score = cap;
                  break;
               end
               score = score * 64'd5 + v;
            end
            r.completion_score = score[SCORE_W-1:0];
         end
         awaited_results.insert(awaited_results.size(), r);
         open_kinds.delete();
         line_corrupt  = 1'b0;
         line_overflow = 1'b0;
         bad_closer    = '0;
      endfunction

      function void report(string what, line_result_type e, line_result_type g);
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display({"[%0t] %s: expected status=%0d bad=%02h syntax=%0d completion=%0d,",
                      " got status=%0d bad=%02h syntax=%0d completion=%0d"},
                     $time, what, e.status, e.bad_char, e.syntax_score, e.completion_score,
                     g.status, g.bad_char, g.syntax_score, g.completion_score);
      endfunction

      // One accepted result beat
      function void check_result(line_result_type got);
         line_result_type e;
         if (awaited_results.size() == 0) begin
            report("result with no line pending", '0, got);
            return;
         end
         e = awaited_results.pop_front();
         if (got !== e) report("result mismatch", e, got);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   bnc_req_if req_bus();
   bnc_rsp_if rsp_bus();

   bracket_nesting_checker dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   bracket_line_board board;
   int unsigned       sender_idle_pct;
   int unsigned       receiver_stall_pct;
   int unsigned       holds_asked;
   int unsigned       holds_served;
   int unsigned       hold_left;
   logic [7:0]        line_buf[$];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // result ready: random stalls, plus a long hold-off when one is asked for
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left     <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (holds_served != holds_asked) begin
         holds_served  <= holds_served + 1;
         hold_left     <= HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   // accepted beats on both channels
   always @(posedge clock) begin : watch
      line_result_type got;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            board.note_char(req_bus.character, req_bus.last);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.status           = status_type'(rsp_bus.status);
            got.bad_char         = rsp_bus.bad_char;
            got.syntax_score     = rsp_bus.syntax_score;
            got.completion_score = rsp_bus.completion_score;
            board.check_result(got);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic logic [7:0] opener_char(kind_type k);
      case (k)
         KIND_ROUND:  return CH_ROUND_OPEN;
         KIND_SQUARE: return CH_SQUARE_OPEN;
         KIND_CURLY:  return CH_CURLY_OPEN;
         default:     return CH_ANGLE_OPEN;
      endcase
   endfunction

   function automatic logic [7:0] closer_char(kind_type k);
      case (k)
         KIND_ROUND:  return CH_ROUND_CLOSE;
         KIND_SQUARE: return CH_SQUARE_CLOSE;
         KIND_CURLY:  return CH_CURLY_CLOSE;
         default:     return CH_ANGLE_CLOSE;
      endcase
   endfunction

   // any byte that is not a bracket
   function automatic logic [7:0] plain_noise();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (c inside {CH_ROUND_OPEN, CH_ROUND_CLOSE, CH_SQUARE_OPEN, CH_SQUARE_CLOSE,
                       CH_CURLY_OPEN, CH_CURLY_CLOSE, CH_ANGLE_OPEN, CH_ANGLE_CLOSE});
      return c;
   endfunction

   function automatic line_shape_type pick_shape();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 33) return LINE_BALANCED;
      if (roll < 58) return LINE_INCOMPLETE;
      if (roll < 78) return LINE_CORRUPT;
      if (roll < 91) return LINE_NOISE;
      if (roll < 96) return LINE_DEEP;
      return LINE_OVERFLOW;
   endfunction

   // Fill line_buf with one line of the given shape
   task automatic build_line(input line_shape_type shape);
      kind_type    open_q[$];
      kind_type    k;
      int unsigned n;
      int unsigned depth_cap;
      int unsigned roll;
      line_buf.delete();
      case (shape)
         LINE_NOISE: begin
            n = $urandom_range(1, 12);
            repeat (n) line_buf.insert(line_buf.size(), 8'($urandom_range(0, 255)));
         end
         LINE_OVERFLOW: begin
            n = STACK_DEPTH_DEF + $urandom_range(1, 4);
            repeat (n)
               line_buf.insert(line_buf.size(), opener_char(kind_type'($urandom_range(0, 3))));
            n = $urandom_range(0, 3);
            repeat (n) line_buf.insert(line_buf.size(), 8'($urandom_range(0, 255)));
         end
         LINE_DEEP: begin
            // 26 to 44 unmatched openers, so the completion score nears or reaches saturation
            n = $urandom_range(26, 44);
            repeat (n) begin
               if ($urandom_range(0, 9) == 0) line_buf.insert(line_buf.size(), plain_noise());
               line_buf.insert(line_buf.size(), opener_char(kind_type'($urandom_range(0, 3))));
            end
         end
         default: begin
            // well-formed random walk with some filler characters
            n         = $urandom_range(1, 16);
            depth_cap = $urandom_range(1, 10);
            repeat (n) begin
               roll = $urandom_range(0, 99);
               if (roll < 10) begin
                  line_buf.insert(line_buf.size(), plain_noise());
               end else if (open_q.size() == 0 || (open_q.size() < depth_cap && roll < 55)) begin
                  k = kind_type'($urandom_range(0, 3));
                  open_q.insert(open_q.size(), k);
                  line_buf.insert(line_buf.size(), opener_char(k));
               end else begin
                  k = open_q[$];
                  open_q.delete(open_q.size() - 1);
                  line_buf.insert(line_buf.size(), closer_char(k));
               end
            end
            case (shape)
               LINE_BALANCED: begin
                  while (open_q.size() != 0) begin
                     k = open_q[$];
                     open_q.delete(open_q.size() - 1);
                     line_buf.insert(line_buf.size(), closer_char(k));
                  end
               end
               LINE_INCOMPLETE: begin
                  if (open_q.size() == 0)
                     line_buf.insert(line_buf.size(),
                                     opener_char(kind_type'($urandom_range(0, 3))));
               end
               default: begin
                  if (open_q.size() == 0) k = kind_type'($urandom_range(0, 3));
                  else k = kind_type'(open_q[$] + $urandom_range(1, 3));
                  line_buf.insert(line_buf.size(), closer_char(k));
                  n = $urandom_range(0, 4);
                  repeat (n) line_buf.insert(line_buf.size(), 8'($urandom_range(0, 255)));
               end
            endcase
         end
      endcase
   endtask

   // Offer one character beat and wait for it to be taken
   task automatic send_beat(input logic [7:0] c, input logic fin);
      while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.character <= c;
      req_bus.last      <= fin;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
   endtask

   task automatic send_line();
      for (int i = 0; i < line_buf.size(); i++)
         send_beat(line_buf[i], i == line_buf.size() - 1);
   endtask

   task automatic send_text(input string s);
      line_buf.delete();
      for (int i = 0; i < s.len(); i++) line_buf.insert(line_buf.size(), s[i]);
      send_line();
   endtask

   // Sender stays quiet until every line verdict has come back
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   initial begin
      int unsigned beats;
      board = new();
      req_bus.valid      <= 1'b0;
      req_bus.character  <= '0;
      req_bus.last       <= 1'b0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      holds_asked        = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed lines: each closer as the first bad one, all pairs nested, extremes
      send_text(")");
      send_text("(]");
      send_text("[}");
      send_text("{>");
      send_text("<([{}])>");
      line_buf = '{8'h00};
      send_line();
      line_buf = '{CH_ROUND_OPEN, CH_ANGLE_OPEN, 8'hFF};
      send_line();
      send_text("(>]");
      wait_drained();

      // random lines under different idling patterns
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct <= 0;
               holds_asked        <= holds_asked + 1;
            end
            1: begin
               sender_idle_pct    = 80;
               receiver_stall_pct <= 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct <= 80;
            end
            default: begin
               sender_idle_pct    = 9;
               receiver_stall_pct <= 9;
            end
         endcase
         if (phase == 1) begin
            build_line(LINE_OVERFLOW);
            send_line();
         end
         if (phase == 2) begin
            build_line(LINE_DEEP);
            send_line();
         end
         beats = 0;
         while (beats < PHASE_BEATS) begin
            build_line(pick_shape());
            send_line();
            beats += line_buf.size();
         end
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
